// File: sv/crsft_pkg.sv
// Shared types, constants and helper functions of the telemetry responder.
package crsft_pkg;

  localparam int unsigned NUM_VALUES    = 12;
  localparam int unsigned IDX_W         = 4;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned MAX_BURST_LEN = 256;
  localparam int unsigned MIN_BURST_LEN = 4;
  localparam int unsigned CNT_W         = $clog2(MAX_BURST_LEN + 1);
  localparam int unsigned BUF_BYTES     = 18;
  localparam int unsigned POS_W         = 5;
  localparam int unsigned STEP_W        = 3;

  localparam logic [7:0] SYNC_BYTE = 8'hC8;
  localparam logic [7:0] CRC_POLY  = 8'hD5;
  localparam logic [7:0] FRAME_ID_GPS   = 8'h02;
  localparam logic [7:0] FRAME_ID_VARIO = 8'h07;
  localparam logic [7:0] FRAME_ID_BATT  = 8'h08;
  localparam logic [7:0] FRAME_ID_BARO  = 8'h09;

  localparam logic signed [VAL_W:0] ALT_OFFSET = 33'sd1000;
  localparam logic signed [VAL_W:0] ALT_MAX    = 33'sd2276;

  localparam logic REG_ENABLED_MASK = 1'b0;

  typedef enum logic [1:0] {
    KIND_GPS   = 2'd0,
    KIND_VARIO = 2'd1,
    KIND_BATT  = 2'd2,
    KIND_BARO  = 2'd3
  } kind_e;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_LINK   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SEND
  } state_e;

  typedef struct packed {
    logic [IDX_W-1:0] entry;
    logic [POS_W-1:0] pos;
    logic [2:0]       nbytes;
    logic             alt;
    logic             last;
  } step_t;

  typedef struct packed {
    logic done;
    logic ok;
  } burst_st_t;

  function automatic step_t mk_step(int unsigned entry, int unsigned pos,
                                    int unsigned nbytes, logic alt, logic last);
    step_t s;
    s.entry  = IDX_W'(entry);
    s.pos    = POS_W'(pos);
    s.nbytes = 3'(nbytes);
    s.alt    = alt;
    s.last   = last;
    return s;
  endfunction

  function automatic step_t step_info(kind_e kind, logic [STEP_W-1:0] step);
    step_t s;
    s = mk_step(0, 3, 4, 1'b0, 1'b1);
    case (kind)
      KIND_GPS: begin
        case (step)
          3'd0:    s = mk_step(0, 3, 4, 1'b0, 1'b0);
          3'd1:    s = mk_step(1, 7, 4, 1'b0, 1'b0);
          3'd2:    s = mk_step(2, 11, 2, 1'b0, 1'b0);
          3'd3:    s = mk_step(3, 13, 2, 1'b0, 1'b0);
          3'd4:    s = mk_step(4, 15, 2, 1'b1, 1'b0);
          default: s = mk_step(5, 17, 1, 1'b0, 1'b1);
        endcase
      end
      KIND_VARIO: s = mk_step(6, 3, 2, 1'b0, 1'b1);
      KIND_BATT: begin
        case (step)
          3'd0:    s = mk_step(7, 3, 2, 1'b0, 1'b0);
          3'd1:    s = mk_step(8, 5, 2, 1'b0, 1'b0);
          default: s = mk_step(9, 7, 3, 1'b0, 1'b1);
        endcase
      end
      default: begin
        case (step)
          3'd0:    s = mk_step(10, 3, 2, 1'b1, 1'b0);
          default: s = mk_step(11, 5, 2, 1'b0, 1'b1);
        endcase
      end
    endcase
    return s;
  endfunction

  function automatic logic [POS_W-1:0] crc_pos(kind_e kind);
    logic [POS_W-1:0] p;
    case (kind)
      KIND_GPS:   p = POS_W'(18);
      KIND_VARIO: p = POS_W'(5);
      KIND_BATT:  p = POS_W'(11);
      default:    p = POS_W'(7);
    endcase
    return p;
  endfunction

  function automatic logic [7:0] type_byte(kind_e kind);
    logic [7:0] t;
    case (kind)
      KIND_GPS:   t = FRAME_ID_GPS;
      KIND_VARIO: t = FRAME_ID_VARIO;
      KIND_BATT:  t = FRAME_ID_BATT;
      default:    t = FRAME_ID_BARO;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] crc_byte(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: sv/crsft_burst_chk.sv
// Received burst tracker: byte count, overflow flag and running CRC-8 check.
module crsft_burst_chk (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  byte_vld_i,
  input  logic [7:0]            byte_i,
  input  logic                  end_i,
  output crsft_pkg::burst_st_t  st_o
);

  localparam int unsigned CW = crsft_pkg::CNT_W;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic [7:0]    crc_q, crc_d;
  logic          ovf_now;

  always_comb begin
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    crc_d   = crc_q;
    st_o    = '0;
    ovf_now = ovf_q | (cnt_q >= CW'(crsft_pkg::MAX_BURST_LEN));
    if (byte_vld_i) begin
      if (!end_i) begin
        if (cnt_q >= CW'(2) && cnt_q < CW'(crsft_pkg::MAX_BURST_LEN)) begin
          crc_d = crsft_pkg::crc_byte(crc_q, byte_i);
        end
        if (cnt_q < CW'(crsft_pkg::MAX_BURST_LEN)) begin
          cnt_d = cnt_q + CW'(1);
        end
        ovf_d = ovf_now;
      end else begin
        st_o.done = 1'b1;
        st_o.ok   = !ovf_now && (cnt_q >= CW'(crsft_pkg::MIN_BURST_LEN - 1)) &&
                    (cnt_q < CW'(crsft_pkg::MAX_BURST_LEN)) && (byte_i == crc_q);
        cnt_d = '0;
        ovf_d = 1'b0;
        crc_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
      crc_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
      crc_q <= crc_d;
    end
  end

`ifndef SYNTH
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(crsft_pkg::MAX_BURST_LEN))
    else $error("burst count above its limit");
  a_ovf_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> cnt_q == CW'(crsft_pkg::MAX_BURST_LEN))
    else $error("overflow flag set with count below the limit");
  a_done_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_o.done |=> (cnt_q == '0 && crc_q == '0 && !ovf_q))
    else $error("burst state not cleared after the last byte");
`endif

endmodule

// File: sv/crsf_telemetry_responder.sv
// Telemetry responder: sensor store, burst check and reply frame generation.
//
// Usage: the slave stream carries two kinds of transaction, selected by tuser.
// tuser 0 writes sensor_value into store entry value_index (indexes above 11
// are dropped). tuser 1 carries one received link byte; tlast marks the last
// byte of a burst. A burst of 4 to 256 bytes whose last byte matches the
// CRC-8 of bytes 2 to n-2 triggers one reply frame on the master stream,
// one byte per transaction, tlast on the closing CRC byte. The frame type is
// picked round-robin among the types enabled in register 0 (APB, offset 0).
// Throughput: one slave transaction per cycle. After a triggering last byte
// the slave side stalls until the frame's store entries (1 to 6) are read
// one at a time, since the store has one read port. A frame leaves at one
// byte per cycle while the master side is ready; its first byte follows the
// store reads. A further triggering burst that ends while a frame is still
// sent is held and stalls the slave side until that frame is done and the
// next frame's entries are read. A master-side stall holds the output
// register and backs up the frame, not the slave side, until a new frame is
// due. Reset clears the store (per-entry valid bits), burst state,
// round-robin pointer and the enable register; no clearing pass is needed.
module crsf_telemetry_responder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // value_index[3:0], sensor_value[35:4],
                                      // rx_byte[43:36], zero[47:44]
  input  logic        s_axis_tuser,   // cmd
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // tx_byte[7:0]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned NV = crsft_pkg::NUM_VALUES;
  localparam int unsigned IW = crsft_pkg::IDX_W;
  localparam int unsigned VW = crsft_pkg::VAL_W;
  localparam int unsigned PW = crsft_pkg::POS_W;
  localparam int unsigned SW = crsft_pkg::STEP_W;
  localparam int unsigned NB = crsft_pkg::BUF_BYTES;

  // Configuration register.
  logic [3:0] mask_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == crsft_pkg::REG_ENABLED_MASK) ? {28'b0, mask_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == crsft_pkg::REG_ENABLED_MASK) begin
      mask_q <= pwdata[3:0];
    end
  end

  // Input unpacking.
  logic          s_acc;
  logic [IW-1:0] in_idx;
  logic [VW-1:0] in_val;
  logic [7:0]    in_byte;
  logic          req_q, req_d;

  assign in_idx        = s_axis_tdata[3:0];
  assign in_val        = s_axis_tdata[35:4];
  assign in_byte       = s_axis_tdata[43:36];
  assign s_axis_tready = !req_q;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // Sensor store.
  logic [VW-1:0] mem_q [NV];
  logic [NV-1:0] vld_q;
  logic          mem_we;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [VW-1:0] rd_data_q;
  logic          rd_vld_q;

  assign mem_we = s_acc && (s_axis_tuser == crsft_pkg::CMD_UPDATE) && (in_idx < IW'(NV));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[in_idx] <= in_val;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_vld_q  <= vld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (mem_we) begin
      vld_q[in_idx] <= 1'b1;
    end
  end

  // Burst check.
  crsft_pkg::burst_st_t burst_st;

  crsft_burst_chk u_burst (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_vld_i (s_acc && (s_axis_tuser == crsft_pkg::CMD_LINK)),
    .byte_i     (in_byte),
    .end_i      (s_axis_tlast),
    .st_o       (burst_st)
  );

  // Round-robin frame type selection.
  crsft_pkg::kind_e next_q, next_d;
  crsft_pkg::kind_e req_kind_q, req_kind_d;
  crsft_pkg::kind_e sel_kind;
  logic             sel_found;

  always_comb begin
    sel_kind  = next_q;
    sel_found = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (!sel_found && mask_q[2'(next_q + 2'(k))]) begin
        sel_kind  = crsft_pkg::kind_e'(2'(next_q + 2'(k)));
        sel_found = 1'b1;
      end
    end
  end

  // Frame sequencer.
  crsft_pkg::state_e state_q, state_d;
  crsft_pkg::kind_e  frm_kind_q, frm_kind_d;
  logic [SW-1:0]     fs_q, fs_d;
  crsft_pkg::step_t  fetch_step;
  logic              cap_vld_q, cap_vld_d;
  crsft_pkg::step_t  cap_step_q;
  logic              init_buf;
  logic [PW-1:0]     snd_idx_q, snd_idx_d;
  logic [7:0]        fcrc_q, fcrc_d;
  logic [7:0]        buf_q [NB];
  logic [7:0]        buf_d [NB];
  logic              out_adv;
  logic              out_load;
  logic              is_crc;
  logic [7:0]        snd_byte;
  logic              m_vld_q;
  logic [7:0]        m_data_q;
  logic              m_last_q;

  assign fetch_step = crsft_pkg::step_info(frm_kind_q, fs_q);
  assign out_adv    = !m_vld_q || m_axis_tready;
  assign is_crc     = (snd_idx_q == crsft_pkg::crc_pos(frm_kind_q));
  assign snd_byte   = is_crc ? fcrc_q : buf_q[snd_idx_q];

  always_comb begin
    state_d    = state_q;
    frm_kind_d = frm_kind_q;
    fs_d       = fs_q;
    req_d      = req_q;
    req_kind_d = req_kind_q;
    next_d     = next_q;
    rd_en      = 1'b0;
    rd_addr    = fetch_step.entry;
    cap_vld_d  = 1'b0;
    init_buf   = 1'b0;
    snd_idx_d  = snd_idx_q;
    fcrc_d     = fcrc_q;
    out_load   = 1'b0;

    if (burst_st.ok && sel_found) begin
      req_d      = 1'b1;
      req_kind_d = sel_kind;
      next_d     = crsft_pkg::kind_e'(2'(sel_kind + 2'd1));
    end

    unique case (state_q)
      crsft_pkg::ST_IDLE: begin
        if (req_q) begin
          state_d    = crsft_pkg::ST_FETCH;
          frm_kind_d = req_kind_q;
          fs_d       = '0;
          init_buf   = 1'b1;
          snd_idx_d  = '0;
          fcrc_d     = '0;
        end
      end
      crsft_pkg::ST_FETCH: begin
        rd_en     = 1'b1;
        cap_vld_d = 1'b1;
        if (fetch_step.last) begin
          state_d = crsft_pkg::ST_SEND;
          req_d   = 1'b0;
        end else begin
          fs_d = fs_q + SW'(1);
        end
      end
      crsft_pkg::ST_SEND: begin
        if (out_adv) begin
          out_load  = 1'b1;
          snd_idx_d = snd_idx_q + PW'(1);
          if (snd_idx_q >= PW'(2) && !is_crc) begin
            fcrc_d = crsft_pkg::crc_byte(fcrc_q, snd_byte);
          end
          if (is_crc) begin
            state_d = crsft_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = crsft_pkg::ST_IDLE;
    endcase
  end

  // Placement of one store entry into the frame buffer.
  logic [VW-1:0]        cap_raw;
  logic signed [VW:0]   alt_sum;
  logic [VW-1:0]        cap_val;
  logic [PW-1:0]        off;
  logic [1:0]           sh;

  always_comb begin
    cap_raw = rd_vld_q ? rd_data_q : '0;
    alt_sum = $signed({cap_raw[VW-1], cap_raw}) + crsft_pkg::ALT_OFFSET;
    cap_val = cap_raw;
    if (cap_step_q.alt) begin
      if (alt_sum < 0) begin
        cap_val = '0;
      end else if (alt_sum > crsft_pkg::ALT_MAX) begin
        cap_val = VW'(crsft_pkg::ALT_MAX);
      end else begin
        cap_val = alt_sum[VW-1:0];
      end
    end
  end

  always_comb begin
    off = '0;
    sh  = '0;
    for (int j = 0; j < NB; j++) begin
      buf_d[j] = buf_q[j];
      if (init_buf) begin
        if (j == 0) begin
          buf_d[j] = crsft_pkg::SYNC_BYTE;
        end else if (j == 1) begin
          buf_d[j] = 8'(crsft_pkg::crc_pos(req_kind_q) - PW'(1));
        end else if (j == 2) begin
          buf_d[j] = crsft_pkg::type_byte(req_kind_q);
        end else begin
          buf_d[j] = '0;
        end
      end else if (cap_vld_q) begin
        off = PW'(j) - cap_step_q.pos;
        if (PW'(j) >= cap_step_q.pos && off < PW'(cap_step_q.nbytes)) begin
          sh = 2'(cap_step_q.nbytes - 3'd1 - off[2:0]);
          case (sh)
            2'd0:    buf_d[j] = cap_val[7:0];
            2'd1:    buf_d[j] = cap_val[15:8];
            2'd2:    buf_d[j] = cap_val[23:16];
            default: buf_d[j] = cap_val[31:24];
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q      <= buf_d;
    cap_step_q <= fetch_step;
    fs_q       <= fs_d;
    frm_kind_q <= frm_kind_d;
    req_kind_q <= req_kind_d;
    snd_idx_q  <= snd_idx_d;
    fcrc_q     <= fcrc_d;
    if (out_load) begin
      m_data_q <= snd_byte;
      m_last_q <= is_crc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= crsft_pkg::ST_IDLE;
      req_q     <= 1'b0;
      next_q    <= crsft_pkg::KIND_GPS;
      cap_vld_q <= 1'b0;
      m_vld_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      req_q     <= req_d;
      next_q    <= next_d;
      cap_vld_q <= cap_vld_d;
      if (out_load) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

`ifndef SYNTH
  a_fetch_has_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == crsft_pkg::ST_FETCH |-> req_q)
    else $error("store fetch without a pending frame request");
  a_no_write_in_fetch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == crsft_pkg::ST_FETCH |-> !mem_we)
    else $error("store written while a frame is being fetched");
  a_cap_in_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_vld_q |-> (state_q == crsft_pkg::ST_FETCH || state_q == crsft_pkg::ST_SEND))
    else $error("entry captured outside of frame generation");
  a_req_from_burst : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(req_q) |-> $past(burst_st.ok && mask_q != 4'b0))
    else $error("frame request without an accepted burst");
`endif

endmodule
